/* rtl/rsnap_pkg.sv */
// rsnap_pkg: shared widths, op and register codes, token types and helpers
// for the rectangle edge snapper; depends on nothing
package rsnap_pkg;

    localparam int MAX_OBSTACLES_DEF = 64;

    localparam int CRD_W     = 15;   // signed coordinate fields
    localparam int SIZE_W    = 14;   // unsigned size and screen fields
    localparam int DIST_W    = 8;    // snap distance
    localparam int OUT_W     = 16;   // snapped result width
    localparam int CW        = 18;   // internal arithmetic width
    localparam int CFG_W     = 14;   // widest config register
    localparam int CFG_IDX_W = 2;

    localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RST  = 14'd1024;
    localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RST = 14'd768;
    localparam logic [DIST_W-1:0] SNAP_DISTANCE_RST = 8'd8;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 2'd0,
        REG_SCREEN_HEIGHT = 2'd1,
        REG_SNAP_DISTANCE = 2'd2
    } cfg_idx_t;

    typedef logic signed [CW-1:0] coord_t;

    // running coordinate and its distance from the proposed position
    typedef struct packed {
        coord_t val;
        coord_t mag;
    } axis_t;

    typedef struct packed {
        logic              vld;
        axis_t             x;
        axis_t             y;
        logic [CRD_W-1:0]  ox;
        logic [CRD_W-1:0]  oy;
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
    } tok_t;

    typedef struct packed {
        logic [CRD_W-1:0] l;
        logic [CRD_W-1:0] t;
        logic [CRD_W-1:0] r;
        logic [CRD_W-1:0] b;
    } obs_t;

    function automatic coord_t sext_crd(logic [CRD_W-1:0] v);
        return coord_t'({{(CW-CRD_W){v[CRD_W-1]}}, v});
    endfunction

    function automatic coord_t zext_size(logic [SIZE_W-1:0] v);
        return coord_t'({{(CW-SIZE_W){1'b0}}, v});
    endfunction

    function automatic coord_t zext_dist(logic [DIST_W-1:0] v);
        return coord_t'({{(CW-DIST_W){1'b0}}, v});
    endfunction

    function automatic coord_t abs_c(coord_t v);
        return (v < 0) ? -v : v;
    endfunction

    // x == orig is the same as a zero distance, so mag == 0 stands for unsnapped
    function automatic axis_t try_snap(axis_t cur, coord_t target, coord_t orig,
                                       coord_t rng);
        coord_t a;
        axis_t  res;
        a   = abs_c(target - orig);
        res = cur;
        if (a <= rng && (a <= cur.mag || cur.mag == '0))
        begin
            res.val = target;
            res.mag = a;
        end
        return res;
    endfunction

endpackage

/* rtl/rsnap_head.sv */
// rsnap_head: snaps a new query to the screen edges and launches its token
// into the cell row; depends on rsnap_pkg
module rsnap_head
    import rsnap_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [CRD_W-1:0]  pos_x,
    input  logic [CRD_W-1:0]  pos_y,
    input  logic [SIZE_W-1:0] win_w,
    input  logic [SIZE_W-1:0] win_h,
    input  coord_t            scr_w,
    input  coord_t            scr_h,
    input  coord_t            snap_rng,
    output tok_t              tok
);

    tok_t tok_reg;
    tok_t tok_next;

    function automatic axis_t screen_snap(coord_t o, coord_t s, coord_t scr, coord_t d);
        coord_t ax;
        coord_t ae;
        axis_t  res;
        ax      = abs_c(o);
        ae      = abs_c(scr - o - s);
        res.val = o;
        res.mag = '0;
        if (ax <= d)
        begin
            res.val = '0;
            res.mag = ax;
        end
        if (ae <= d)
        begin
            res.val = scr - s;
            res.mag = ae;
        end
        return res;
    endfunction

    always_comb
    begin
        tok_next     = tok_reg;
        tok_next.vld = 1'b0;
        if (start)
        begin
            tok_next.vld = 1'b1;
            tok_next.ox  = pos_x;
            tok_next.oy  = pos_y;
            tok_next.w   = win_w;
            tok_next.h   = win_h;
            tok_next.x   = screen_snap(sext_crd(pos_x), zext_size(win_w), scr_w, snap_rng);
            tok_next.y   = screen_snap(sext_crd(pos_y), zext_size(win_h), scr_h, snap_rng);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg.vld <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok = tok_reg;

endmodule

/* rtl/rsnap_cell.sv */
// rsnap_cell: one obstacle slot of the row; applies its obstacle to the
// passing token, x half then y half; depends on rsnap_pkg
module rsnap_cell
    import rsnap_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  obs_t   obs_in,
    input  logic   used,
    input  coord_t snap_rng,
    input  tok_t   tok_in,
    output tok_t   tok_out
);

    obs_t   obs_reg;
    tok_t   mid_reg;
    tok_t   mid_next;
    tok_t   tok_reg;
    tok_t   tok_next;
    axis_t  x_step;
    axis_t  y_step;
    coord_t l_c;
    coord_t t_c;
    coord_t r_c;
    coord_t b_c;

    assign l_c = sext_crd(obs_reg.l);
    assign t_c = sext_crd(obs_reg.t);
    assign r_c = sext_crd(obs_reg.r);
    assign b_c = sext_crd(obs_reg.b);

    // x half: needs vertical overlap with the current y
    always_comb
    begin
        mid_next = tok_in;
        x_step   = tok_in.x;
        if (tok_in.vld && used &&
            (t_c - snap_rng - zext_size(tok_in.h)) < tok_in.y.val &&
            (b_c + snap_rng) > tok_in.y.val)
        begin
            x_step     = try_snap(tok_in.x, r_c, sext_crd(tok_in.ox), snap_rng);
            mid_next.x = try_snap(x_step, l_c - zext_size(tok_in.w),
                                  sext_crd(tok_in.ox), snap_rng);
        end
    end

    // y half: horizontal overlap uses the x just updated
    always_comb
    begin
        tok_next = mid_reg;
        y_step   = mid_reg.y;
        if (mid_reg.vld && used &&
            (l_c - snap_rng - zext_size(mid_reg.w)) < mid_reg.x.val &&
            (r_c + snap_rng) > mid_reg.x.val)
        begin
            y_step     = try_snap(mid_reg.y, b_c, sext_crd(mid_reg.oy), snap_rng);
            tok_next.y = try_snap(y_step, t_c - zext_size(mid_reg.h),
                                  sext_crd(mid_reg.oy), snap_rng);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            obs_reg <= obs_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg.vld <= 1'b0;
            tok_reg.vld <= 1'b0;
        end
        else
        begin
            mid_reg <= mid_next;
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

/* rtl/rectangle_edge_snapper.sv */
// rectangle_edge_snapper: top level, obstacle row, config and result buffering
// a query result passes the head register, then each obstacle cell, where the x
// half and then the y half are registered, then the pending and output registers
// in_ready is low while a query is busy; clear and append complete when taken
// reset: obstacle count, busy flag and result valids clear, registers take defaults;
// obstacle storage is not cleared, only slots below the count are used
module rectangle_edge_snapper
    import rsnap_pkg::*;
#(
    parameter int MAX_OBSTACLES = MAX_OBSTACLES_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              op,
    input  logic [CRD_W-1:0]        rect_left,
    input  logic [CRD_W-1:0]        rect_top,
    input  logic [CRD_W-1:0]        rect_right,
    input  logic [CRD_W-1:0]        rect_bottom,
    input  logic [CRD_W-1:0]        pos_x,
    input  logic [CRD_W-1:0]        pos_y,
    input  logic [SIZE_W-1:0]       win_width,
    input  logic [SIZE_W-1:0]       win_height,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] snapped_x,
    output logic signed [OUT_W-1:0] snapped_y
);

    localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);

    logic [SIZE_W-1:0] scr_w_reg;
    logic [SIZE_W-1:0] scr_h_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              busy_reg;
    logic              busy_next;
    logic              pend_vld_reg;
    logic              pend_vld_next;
    logic [OUT_W-1:0]  pend_x_reg;
    logic [OUT_W-1:0]  pend_y_reg;
    logic              out_vld_reg;
    logic              out_vld_next;
    logic [OUT_W-1:0]  out_x_reg;
    logic [OUT_W-1:0]  out_y_reg;

    logic   in_xfer;
    logic   start;
    logic   app_xfer;
    logic   pend_move;
    coord_t dist_c;
    obs_t   obs_in;
    tok_t   chain [0:MAX_OBSTACLES];

    assign in_ready  = !busy_reg;
    assign in_xfer   = in_valid && in_ready;
    assign start     = in_xfer && (op == OP_QUERY);
    assign app_xfer  = in_xfer && (op == OP_APPEND);
    assign pend_move = pend_vld_reg && (!out_vld_reg || out_ready);
    assign dist_c    = zext_dist(dist_reg);

    assign obs_in.l = rect_left;
    assign obs_in.t = rect_top;
    assign obs_in.r = rect_right;
    assign obs_in.b = rect_bottom;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg <= SCREEN_WIDTH_RST;
            scr_h_reg <= SCREEN_HEIGHT_RST;
            dist_reg  <= SNAP_DISTANCE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  scr_w_reg <= cfg_data[SIZE_W-1:0];
                REG_SCREEN_HEIGHT: scr_h_reg <= cfg_data[SIZE_W-1:0];
                REG_SNAP_DISTANCE: dist_reg  <= cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    rsnap_head u_head (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .win_w    (win_width),
        .win_h    (win_height),
        .scr_w    (zext_size(scr_w_reg)),
        .scr_h    (zext_size(scr_h_reg)),
        .snap_rng (dist_c),
        .tok      (chain[0])
    );

    for (genvar i = 0; i < MAX_OBSTACLES; i++)
    begin : g_cell
        rsnap_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .wr_en    (app_xfer && (count_reg == CNT_W'(i))),
            .obs_in   (obs_in),
            .used     (count_reg > CNT_W'(i)),
            .snap_rng (dist_c),
            .tok_in   (chain[i]),
            .tok_out  (chain[i+1])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (in_xfer && (op == OP_CLEAR))
        begin
            count_next = '0;
        end
        else if (app_xfer && (count_reg < CNT_W'(MAX_OBSTACLES)))
        begin
            count_next = count_reg + 1'b1;
        end

        busy_next = busy_reg;
        if (start)
        begin
            busy_next = 1'b1;
        end
        else if (pend_move)
        begin
            busy_next = 1'b0;
        end

        pend_vld_next = pend_vld_reg;
        if (chain[MAX_OBSTACLES].vld)
        begin
            pend_vld_next = 1'b1;
        end
        else if (pend_move)
        begin
            pend_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (pend_move)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            busy_reg     <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            busy_reg     <= busy_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chain[MAX_OBSTACLES].vld)
        begin
            pend_x_reg <= chain[MAX_OBSTACLES].x.val[OUT_W-1:0];
            pend_y_reg <= chain[MAX_OBSTACLES].y.val[OUT_W-1:0];
        end
        if (pend_move)
        begin
            out_x_reg <= pend_x_reg;
            out_y_reg <= pend_y_reg;
        end
    end

    assign out_valid = out_vld_reg;
    assign snapped_x = out_x_reg;
    assign snapped_y = out_y_reg;

    // a waiting result always belongs to the query still marked busy
    a_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pend_vld_reg |-> busy_reg)
        else $error("pending result without busy query");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_OBSTACLES))
        else $error("obstacle count above capacity");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("query transfer did not set busy");

    // busy drops only when the result lands in the output register
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> out_vld_reg)
        else $error("query finished without a result");

endmodule
